### sv/htwd_pkg.sv
package htwd_pkg;

    // Field widths of the two channels and of the configuration port
    localparam int NODE_W  = 16;
    localparam int SYM_W   = 15;
    localparam int IDX_W   = 10;
    localparam int WC_W    = 14;
    localparam int CFG_W   = 32;
    localparam int CFGI_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int BITC_W  = 3;

    // Node ids at and above this value are internal nodes
    localparam logic [NODE_W-1:0] INTERNAL_BASE = 16'd32768;

    // Reciprocal of three scaled by 2^16; exact for every 15-bit symbol
    localparam logic [SYM_W-1:0] DIV3_RECIP = 15'd21846;

    // Last bit position within a data byte
    localparam logic [BITC_W-1:0] LAST_BIT = 3'd7;

    // Input command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_ROOT  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_TOTAL = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MAP   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // Symbol held back until it is known whether it ends the byte
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol;
        logic             all_done;
    } pend_t;

    // Control strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic step;
        logic emit;
        logic push_mid;
        logic push_last;
    } ctrl_t;

endpackage

### sv/htwd_in_if.sv
interface htwd_in_if;
    import htwd_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [IDX_W-1:0]  node_index;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic [BYTE_W-1:0] data_byte;

    modport source (
        output valid, cmd, node_index, left_child, right_child, data_byte,
        input  ready
    );

    modport sink (
        input  valid, cmd, node_index, left_child, right_child, data_byte,
        output ready
    );

endinterface

### sv/htwd_out_if.sv
interface htwd_out_if;
    import htwd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SYM_W-1:0]   symbol;
    logic [WC_W-1:0]    width_code;
    logic signed [1:0]  shift_code;
    logic               last_of_byte;
    logic               all_done;

    modport source (
        output valid, symbol, width_code, shift_code, last_of_byte, all_done,
        input  ready
    );

    modport sink (
        input  valid, symbol, width_code, shift_code, last_of_byte, all_done,
        output ready
    );

endinterface

### sv/htwd_ram.sv
module htwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/htwd_map.sv
module htwd_map (
    input  logic                      map_en,
    input  logic [htwd_pkg::SYM_W-1:0] symbol,
    output logic [htwd_pkg::WC_W-1:0]  width_code,
    output logic signed [1:0]          shift_code
);
    import htwd_pkg::*;

    localparam int PROD_W = 2 * SYM_W;

    logic [PROD_W-1:0] prod;
    logic [WC_W-1:0]   quot;
    logic [1:0]        q3_lo;
    logic [1:0]        rem;
    logic [1:0]        shift_raw;

    // Quotient by three through the scaled reciprocal
    assign prod = PROD_W'(symbol) * PROD_W'(DIV3_RECIP);
    assign quot = prod[PROD_W-1 -: WC_W];

    // The remainder is below three, so two low bits of symbol - 3q suffice
    assign q3_lo     = quot[1:0] + {quot[0], 1'b0};
    assign rem       = symbol[1:0] - q3_lo;
    assign shift_raw = rem - 2'd1;

    // Both codes read as zero outside map mode
    assign width_code = map_en ? quot : '0;
    assign shift_code = map_en ? $signed(shift_raw) : 2'sd0;

endmodule

### sv/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder.
// The input channel carries two kinds of item. A node write (cmd 0) stores the
// left and right child ids of one internal node and leaves the block idle. A
// decode item (cmd 1) carries one coded byte that is walked most significant
// bit first through the node memory, one bit per cycle unless halted: a 1
// bit takes the left child, a 0 bit the right child, and every leaf reached
// gives one result on the output channel. A walk cut by the end of a byte
// resumes in the next. A decode item passes through the bit steps, a step that
// releases the last symbol of the byte and an idle state with ready high, and
// no new item is taken before that idle state. The bit rate is set by the
// dependent node memory reads, one per bit through the registered read port.
// Each result passes through the held symbol and the output register; the last
// of a byte leaves at the end of the byte, with last_of_byte set. A stalled receiver
// halts the walk when a third symbol would form while two are waiting, one in
// the output register and one held back. Configuration writes through cfg_we,
// cfg_index and cfg_data take effect at the next edge and belong between items,
// while the block is idle. Reset restores root 32768, a symbol total of zero
// and plain mode; the node memory holds no defined contents until written.
module huffman_tree_walk_decoder #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    htwd_in_if.sink                       in_ch,
    htwd_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [htwd_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [htwd_pkg::CFG_W-1:0]    cfg_data
);
    import htwd_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // Configuration and walk state
    logic [NODE_W-1:0] root_reg;
    logic [CFG_W-1:0]  total_reg;
    logic              map_reg;
    logic [NODE_W-1:0] cur_reg;
    logic [CFG_W-1:0]  count_reg;
    logic [BYTE_W-1:0] bits_reg;
    logic [BITC_W-1:0] bitc_reg;
    pend_t             pend_reg;
    state_t            state_reg;
    state_t            state_next;
    ctrl_t             ctrl;

    // Output register
    logic              out_valid_reg;
    logic [SYM_W-1:0]  out_sym_reg;
    logic [WC_W-1:0]   out_wc_reg;
    logic signed [1:0] out_sc_reg;
    logic              out_last_reg;
    logic              out_done_reg;

    // Node memory ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    logic              wr_ok;
    logic              cur_internal;
    logic              slot_ok;
    logic [NODE_W-1:0] child;
    logic [NODE_W-1:0] node_next;
    logic [NODE_W-1:0] rd_node;
    logic              is_leaf;
    logic              stopped;
    logic              out_free;
    logic [CFG_W-1:0]  count_inc;
    logic              accept;
    logic [WC_W-1:0]   map_wc;
    logic signed [1:0] map_sc;

    htwd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    htwd_map u_map (
        .map_en     (map_reg),
        .symbol     (pend_reg.symbol),
        .width_code (map_wc),
        .shift_code (map_sc)
    );

    // Child selection for the bit at the head of the shift register
    assign cur_internal = cur_reg[NODE_W-1];
    assign slot_ok      = cur_internal
                          && ({1'b0, cur_reg[SYM_W-1:0]} < NODE_W'(MAX_NODES));
    assign child        = slot_ok ? (bits_reg[BYTE_W-1] ? ram_rdata[15:0]
                                                        : ram_rdata[31:16])
                                  : '0;
    assign node_next    = cur_internal ? child : cur_reg;
    assign is_leaf      = !node_next[NODE_W-1];
    assign stopped      = count_reg >= total_reg;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign count_inc    = count_reg + 32'd1;
    assign accept       = in_ch.valid && ctrl.in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.cmd == CMD_DECODE)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stopped)
                begin
                    state_next = ST_FLUSH;
                end
                else if (ctrl.step && bitc_reg == LAST_BIT)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_reg.valid || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_WALK:
            begin
                // A second symbol may only form once the held one can leave
                ctrl.step     = !stopped && !(is_leaf && pend_reg.valid && !out_free);
                ctrl.emit     = ctrl.step && is_leaf;
                ctrl.push_mid = ctrl.emit && pend_reg.valid;
            end
            ST_FLUSH:
            begin
                ctrl.push_last = pend_reg.valid && out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Node memory access: writes from node items, reads follow the walk
    assign wr_ok     = {6'b0, in_ch.node_index} < NODE_W'(MAX_NODES);
    assign ram_we    = accept && in_ch.cmd == CMD_WRITE && wr_ok;
    assign ram_waddr = AW'(in_ch.node_index);
    assign ram_wdata = {in_ch.right_child, in_ch.left_child};
    assign rd_node   = ctrl.step ? (is_leaf ? root_reg : node_next) : cur_reg;
    assign ram_raddr = AW'(rd_node[SYM_W-1:0]);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers, walk position and symbol count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= INTERNAL_BASE;
            total_reg <= '0;
            map_reg   <= 1'b0;
            cur_reg   <= INTERNAL_BASE;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROOT:
                begin
                    root_reg <= cfg_data[NODE_W-1:0];
                    cur_reg  <= cfg_data[NODE_W-1:0];
                end
                CFG_TOTAL:
                begin
                    total_reg <= cfg_data;
                    count_reg <= '0;
                    cur_reg   <= root_reg;
                end
                CFG_MAP:
                begin
                    map_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.step)
        begin
            cur_reg <= is_leaf ? root_reg : node_next;
            if (ctrl.emit)
            begin
                count_reg <= count_inc;
            end
        end
    end

    // Bit shift register for the byte under decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitc_reg <= '0;
        end
        else if (accept)
        begin
            bitc_reg <= '0;
        end
        else if (ctrl.step)
        begin
            bitc_reg <= bitc_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bits_reg <= in_ch.data_byte;
        end
        else if (ctrl.step)
        begin
            bits_reg <= {bits_reg[BYTE_W-2:0], 1'b0};
        end
    end

    // Held symbol
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (ctrl.emit)
        begin
            pend_reg.valid    <= 1'b1;
            pend_reg.symbol   <= node_next[SYM_W-1:0];
            pend_reg.all_done <= count_inc == total_reg;
        end
        else if (ctrl.push_last)
        begin
            pend_reg.valid <= 1'b0;
        end
    end

    // Output register: one transfer leaves whenever the receiver is ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.push_mid || ctrl.push_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push_mid || ctrl.push_last)
        begin
            out_sym_reg  <= pend_reg.symbol;
            out_wc_reg   <= map_wc;
            out_sc_reg   <= map_sc;
            out_last_reg <= ctrl.push_last;
            out_done_reg <= pend_reg.all_done;
        end
    end

    assign in_ch.ready         = ctrl.in_ready;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.symbol       = out_sym_reg;
    assign out_ch.width_code   = out_wc_reg;
    assign out_ch.shift_code   = out_sc_reg;
    assign out_ch.last_of_byte = out_last_reg;
    assign out_ch.all_done     = out_done_reg;

    // The count never runs past the configured total
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= total_reg)
        else $error("symbol count exceeds total");

    // No symbol is held back between bytes
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_reg.valid)
        else $error("held symbol left over at end of byte");

    // A finished stream leaves the count at the total
    a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg && !cfg_we) |-> count_reg == total_reg)
        else $error("all_done with count short of total");

    // A symbol only forms while the output path can take the held one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push_mid |-> out_free)
        else $error("held symbol pushed into a full output register");

endmodule

### verif/huffman_symbol_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the tree-walk decoder.
// Every decode transfer is walked through a private copy of the code tree
// and the symbols that it should give are queued; every output transfer is
// compared with the oldest queued symbol.
module huffman_symbol_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    htwd_in_if                          in_ch,
    htwd_out_if                         out_ch,
    input  logic                        cfg_we,
    input  logic [htwd_pkg::CFGI_W-1:0] cfg_index,
    input  logic [htwd_pkg::CFG_W-1:0]  cfg_data,
    output int                          mismatch_count,
    output int                          symbols_outstanding
);
    import htwd_pkg::*;

    localparam int TREE_SLOTS = 1024;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [WC_W-1:0]   width_code;
        logic signed [1:0] shift_code;
        logic              last_of_byte;
        logic              all_done;
    } decoded_sym_t;

    // Private copy of the tree, the walk position and the registers
    bit [31:0]         tree_mem [TREE_SLOTS];
    logic [NODE_W-1:0] walk_node;
    logic [31:0]       symbols_seen;
    logic [NODE_W-1:0] root_id;
    logic [31:0]       total_limit;
    logic              map_on;

    decoded_sym_t symbols_due[$];

    // Walk one coded byte, most significant bit first, and queue its symbols.
    task automatic walk_coded_byte(input logic [BYTE_W-1:0] coded);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] slot;
        logic [31:0]       entry;
        decoded_sym_t      sym;
        int                rem;
        int                found;
        found = 0;
        for (int k = 0; k < BYTE_W; k++) begin
            if (symbols_seen >= total_limit)
                break;
            node = walk_node;
            if (node >= INTERNAL_BASE)
            begin
                slot  = node - INTERNAL_BASE;
                entry = (slot < TREE_SLOTS) ? tree_mem[slot[IDX_W-1:0]] : '0;
                node  = coded[BYTE_W-1-k] ? entry[15:0] : entry[31:16];
            end
            if (node < INTERNAL_BASE)
            begin
                symbols_seen     = symbols_seen + 32'd1;
                sym.symbol       = node[SYM_W-1:0];
                rem              = int'(sym.symbol % 3);
                sym.width_code   = map_on ? WC_W'(sym.symbol / 3) : '0;
                sym.shift_code   = map_on ? 2'(rem - 1) : '0;
                sym.last_of_byte = 1'b0;
                sym.all_done     = (symbols_seen == total_limit);
                symbols_due.push_back(sym);
                walk_node        = root_id;
                found++;
            end
            else
            begin
                walk_node = node;
            end
        end
        // The final symbol of the byte carries the end-of-byte flag.
        if (found > 0)
        begin
            sym = symbols_due.pop_back();
            sym.last_of_byte = 1'b1;
            symbols_due.push_back(sym);
        end
    endtask

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_sym_t want;
        if (!rst_n)
        begin
            walk_node           = INTERNAL_BASE;
            symbols_seen        = '0;
            root_id             = INTERNAL_BASE;
            total_limit         = '0;
            map_on              = 1'b0;
            mismatch_count      = 0;
            symbols_due.delete();
            symbols_outstanding = 0;
        end
        else
        begin
            // Output transfers are checked before this edge's input is walked.
            if (out_ch.valid && out_ch.ready)
            begin
                if (symbols_due.size() == 0)
                begin
                    $display("%0t: unexpected symbol, expected none, actual %0d",
                             $time, out_ch.symbol);
                    mismatch_count++;
                end
                else
                begin
                    want = symbols_due.pop_front();
                    compare_field("symbol", want.symbol, out_ch.symbol);
                    compare_field("width_code", want.width_code, out_ch.width_code);
                    compare_field("shift_code", $signed(want.shift_code),
                                  $signed(out_ch.shift_code));
                    compare_field("last_of_byte", want.last_of_byte, out_ch.last_of_byte);
                    compare_field("all_done", want.all_done, out_ch.all_done);
                end
            end

            // Register writes; a new root or a new total restarts the walk.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROOT:
                    begin
                        root_id   = cfg_data[NODE_W-1:0];
                        walk_node = root_id;
                    end
                    CFG_TOTAL:
                    begin
                        total_limit  = cfg_data;
                        symbols_seen = '0;
                        walk_node    = root_id;
                    end
                    CFG_MAP:
                        map_on = cfg_data[0];
                    default: ;
                endcase
            end

            // Input transfers either load a node or decode a byte.
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.cmd == CMD_WRITE)
                    tree_mem[in_ch.node_index] = {in_ch.right_child, in_ch.left_child};
                else
                    walk_coded_byte(in_ch.data_byte);
            end

            symbols_outstanding = symbols_due.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import htwd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // A decode transfer keeps the block busy until its byte is walked and flushed.
    localparam int SETTLE_CYCLES = 16;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int mismatch_count;
    int symbols_outstanding;
    int gap_pct;
    int stall_pct;
    int cycle_count = 0;

    // Node slots that hold defined contents; walks only ever reach these.
    bit slot_loaded [1024];
    int loaded_slots[$];

    htwd_in_if  in_ch();
    htwd_out_if out_ch();

    huffman_tree_walk_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    huffman_symbol_checker sym_chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_ch               (in_ch),
        .out_ch              (out_ch),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .symbols_outstanding (symbols_outstanding)
    );

    always #6 clk = ~clk;

    // Receiver: stalls at random with the current stall rate.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Present one item after a random gap and hold it until its transfer.
    // Valid is left high so that a following item can go out without a gap.
    task automatic push_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [NODE_W-1:0] lc, input logic [NODE_W-1:0] rc,
                             input logic [BYTE_W-1:0] coded);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.node_index  <= idx;
        in_ch.left_child  <= lc;
        in_ch.right_child <= rc;
        in_ch.data_byte   <= coded;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_node(input int slot, input logic [NODE_W-1:0] lc,
                             input logic [NODE_W-1:0] rc);
        push_item(CMD_WRITE, IDX_W'(slot), lc, rc, BYTE_W'($urandom));
        if (!slot_loaded[slot])
        begin
            slot_loaded[slot] = 1'b1;
            loaded_slots.push_back(slot);
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] coded);
        push_item(CMD_DECODE, IDX_W'($urandom), NODE_W'($urandom), NODE_W'($urandom), coded);
    endtask

    // A child is a random leaf or a slot that already holds a node.
    function automatic logic [NODE_W-1:0] pick_child();
        int n;
        n = loaded_slots.size();
        if (n == 0 || $urandom_range(0, 1) == 0)
            return NODE_W'($urandom_range(0, INTERNAL_BASE - 1));
        return INTERNAL_BASE + NODE_W'(loaded_slots[$urandom_range(0, n - 1)]);
    endfunction

    // Drop valid, wait for every queued symbol and let the block fall idle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (symbols_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write the registers selected by the mask back to back, then release.
    task automatic program_regs(input logic [2:0] mask, input logic [CFG_W-1:0] root,
                                input logic [CFG_W-1:0] total, input logic map);
        if (mask[CFG_ROOT])
            reg_write(CFG_ROOT, root);
        if (mask[CFG_TOTAL])
            reg_write(CFG_TOTAL, total);
        if (mask[CFG_MAP])
            reg_write(CFG_MAP, CFG_W'(map));
        cfg_we <= 1'b0;
    endtask

    // Random trees, new settings and random coded bytes under one idling mix.
    task automatic run_regime(input int gap, input int stall, input int n_items);
        int               sent;
        int               root_slot;
        int               extra;
        int               burst;
        int               slot;
        logic [CFG_W-1:0] total;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_items)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       root_slot = 0;
                1:       root_slot = 1023;
                default: root_slot = $urandom_range(0, 1023);
            endcase
            extra = $urandom_range(2, 8);
            repeat (extra) send_node($urandom_range(0, 1023), pick_child(), pick_child());
            send_node(root_slot, pick_child(), pick_child());
            sent += extra + 1;
            wait_idle();

            case ($urandom_range(0, 3))
                0:       total = $urandom_range(1, 24);
                1:       total = '1;
                2:       total = $urandom;
                default: total = $urandom_range(25, 200);
            endcase
            program_regs(3'($urandom_range(1, 7)), INTERNAL_BASE + CFG_W'(root_slot),
                         total, 1'($urandom));

            // Mostly coded bytes, with the odd node rewritten mid-stream.
            burst = $urandom_range(15, 40);
            if (burst > n_items - sent)
                burst = n_items - sent;
            repeat (burst)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    slot = $urandom_range(0, 1) ? loaded_slots[$urandom_range(0,
                           loaded_slots.size() - 1)] : $urandom_range(0, 1023);
                    send_node(slot, pick_child(), pick_child());
                end
                else
                begin
                    send_byte(BYTE_W'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ROOT;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_WRITE;
        in_ch.node_index  <= '0;
        in_ch.left_child  <= '0;
        in_ch.right_child <= '0;
        in_ch.data_byte   <= '0;
        gap_pct   = 34;
        stall_pct = 46;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // After reset the total is zero, so the byte is ignored.
        send_node(0, 16'd0, INTERNAL_BASE - 16'd1);
        send_byte(8'hA5);
        wait_idle();
        program_regs(3'b111, CFG_W'(INTERNAL_BASE), '1, 1'b1);

        // Extreme leaves, then a deeper tree with a self loop at the top slot.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_node(1023, INTERNAL_BASE + 16'd1023, INTERNAL_BASE);
        send_node(1, 16'd2, 16'd1);
        send_node(0, INTERNAL_BASE + 16'd1, INTERNAL_BASE - 16'd1);
        send_byte(8'hC3);
        send_byte(8'h80);
        // A walk cut by the end of a byte carries into the next one.
        send_byte(8'h01);
        send_byte(8'h7F);
        wait_idle();

        // A new root restarts the walk; this byte ends mid-walk with no symbol.
        program_regs(3'b001, CFG_W'(INTERNAL_BASE + 16'd1023), '0, 1'b0);
        send_byte(8'hFE);
        wait_idle();
        program_regs(3'b001, CFG_W'(INTERNAL_BASE), '0, 1'b0);
        send_byte(8'h40);
        wait_idle();

        // Total reached inside a byte, then further bits ignored.
        program_regs(3'b110, '0, 32'd3, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_idle();
        program_regs(3'b010, '0, '0, 1'b0);
        send_byte(8'h55);
        wait_idle();

        // A leaf used as root gives that leaf for every bit.
        program_regs(3'b011, 32'd12345, '1, 1'b0);
        send_byte(8'h9C);
        wait_idle();
        program_regs(3'b100, '0, '0, 1'b1);
        send_byte(8'h3A);
        wait_idle();
        program_regs(3'b001, CFG_W'(INTERNAL_BASE), '0, 1'b0);

        run_regime(34, 46, 120);
        run_regime(46, 34, 120);
        run_regime(0, 0, 120);
        wait_idle();

        if (mismatch_count == 0 && symbols_outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
